### hdl/gap_framed_bus_receiver_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the gap-framed bus receiver
// ---------------------------------------------------------------------------
`ifndef GAP_FRAMED_BUS_RECEIVER_MACROS_SVH
`define GAP_FRAMED_BUS_RECEIVER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define GFBR_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GFBR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/gfbr_pkg.sv
// ---------------------------------------------------------------------------
// gfbr_pkg
// Types, event codes and the CRC-16 step used by the receiver.
// ---------------------------------------------------------------------------
package gfbr_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 20;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_TIMEOUT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ADDRESS   = 2'd1;

    localparam logic [19:0] TIMEOUT_RESET = 20'd280;

    localparam logic [2:0] EV_BUSY     = 3'd0;
    localparam logic [2:0] EV_PAYLOAD  = 3'd1;
    localparam logic [2:0] EV_EMPTY    = 3'd2;
    localparam logic [2:0] EV_OTHER    = 3'd3;
    localparam logic [2:0] EV_CRC_ERR  = 3'd4;
    localparam logic [2:0] EV_LEN_ERR  = 3'd5;
    localparam logic [2:0] EV_STRAY    = 3'd6;
    localparam logic [2:0] EV_GAP_CUT  = 3'd7;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] TALLY_MAX = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] time_us;
    } gfbr_in_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  payload_byte;
        logic [5:0]  payload_index;
        logic        last;
        logic [15:0] error_count;
    } gfbr_out_t;

    // Modbus CRC-16, one byte, LSB first
    function automatic logic [15:0] crc16_byte(logic [15:0] crc_in, logic [7:0] data_byte);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data_byte};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### hdl/gfbr_payload_buf.sv
// ---------------------------------------------------------------------------
// gfbr_payload_buf
// Payload byte store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module gfbr_payload_buf #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_byte,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_byte
);

    logic [7:0] payload_mem [DEPTH];
    logic [7:0] rd_byte_reg;

    always_ff @(posedge aclk) begin
        if (wr_en && ({1'b0, wr_addr} < (AW+1)'(DEPTH))) begin
            payload_mem[wr_addr] <= wr_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if ({1'b0, rd_addr} < (AW+1)'(DEPTH)) begin
            rd_byte_reg <= payload_mem[rd_addr];
        end
    end

    assign rd_byte = rd_byte_reg;

endmodule

### hdl/gap_framed_bus_receiver.sv
// ---------------------------------------------------------------------------
// gap_framed_bus_receiver
// Gap-framed serial bus receiver with CRC-16 check, error tally and
// delivery of payload bytes from an on-chip buffer.
// ---------------------------------------------------------------------------
//  channel | ports                          | carries
//  --------+--------------------------------+-------------------------------
//  input   | s_valid s_ready s_data         | received byte and timestamp
//  result  | m_valid m_ready m_data         | event, payload byte, tally
//  config  | cfg_valid cfg_ready cfg_index  | register writes
//          | cfg_data                       |
//
// Most bytes give one result. A byte cut off by a gap gives two results.
// The CRC high byte of a delivered frame gives one result per payload
// byte: the payload buffer is read one entry per cycle unless m_ready stalls.
// Reset is synchronous; the payload buffer is not cleared, as only entries
// written in the current frame are read. A stalled result holds the input
// channel; register writes are always taken.
// ---------------------------------------------------------------------------
`include "gap_framed_bus_receiver_macros.svh"

module gap_framed_bus_receiver #(
    parameter int PAYLOAD_MAX = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  gfbr_pkg::gfbr_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output gfbr_pkg::gfbr_out_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gfbr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gfbr_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import gfbr_pkg::*;

    localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
    localparam logic [7:0] PMAX_B = 8'(PAYLOAD_MAX);
    localparam logic [6:0] PMAX_L = 7'(PAYLOAD_MAX);

    typedef enum logic [6:0] {
        PH_IDLE = 7'b0000001,
        PH_ADDR = 7'b0000010,
        PH_LEN  = 7'b0000100,
        PH_DATA = 7'b0001000,
        PH_CRCL = 7'b0010000,
        PH_CRCH = 7'b0100000,
        PH_SKIP = 7'b1000000
    } phase_t;

    typedef enum logic [2:0] {
        ST_IN     = 3'b001,
        ST_SECOND = 3'b010,
        ST_DRAIN  = 3'b100
    } ctl_t;

    ctl_t        ctl_reg, ctl_next;
    phase_t      phase_reg, phase_next;
    logic [31:0] last_time_reg, last_time_next;
    logic [7:0]  frame_addr_reg, frame_addr_next;
    logic [6:0]  frame_len_reg, frame_len_next;
    logic [6:0]  position_reg, position_next;
    logic [7:0]  crc_low_reg, crc_low_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] tally_reg, tally_next;
    logic [6:0]  good_cnt_reg, good_cnt_next;
    logic [6:0]  drain_idx_reg, drain_idx_next;
    logic [19:0] timeout_reg;
    logic [7:0]  own_addr_reg;
    logic        m_valid_reg, m_valid_next;
    gfbr_out_t   m_data_reg, m_data_next;

    logic        out_free;
    logic        out_load;
    logic        buf_wr_en;
    logic [7:0]  buf_rd_byte;

    // per-byte decode
    logic [31:0] gap;
    logic        gap_hit;
    logic        cut;
    logic        err_inc;
    logic        err_dec;
    logic        start_drain;
    phase_t      eff_phase;
    logic [15:0] crc_fed;
    logic [6:0]  pos_inc;
    logic [2:0]  ev;
    logic        drain_last;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (ctl_reg == ST_IN) && out_free;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign gap        = s_data.time_us - last_time_reg;
    assign gap_hit    = gap > {12'd0, timeout_reg};
    assign cut        = gap_hit && (phase_reg != PH_IDLE) && (phase_reg != PH_SKIP);
    assign crc_fed    = crc16_byte(gap_hit ? CRC_INIT : crc_reg, s_data.rx_byte);
    assign pos_inc    = position_reg + 7'd1;
    assign drain_last = (drain_idx_reg + 7'd1) == frame_len_reg;

    always_comb begin
        ctl_next        = ctl_reg;
        phase_next      = phase_reg;
        last_time_next  = last_time_reg;
        frame_addr_next = frame_addr_reg;
        frame_len_next  = frame_len_reg;
        position_next   = position_reg;
        crc_low_next    = crc_low_reg;
        crc_next        = crc_reg;
        tally_next      = tally_reg;
        good_cnt_next   = good_cnt_reg;
        drain_idx_next  = drain_idx_reg;
        out_load        = 1'b0;
        m_data_next     = m_data_reg;
        buf_wr_en       = 1'b0;
        err_inc         = 1'b0;
        err_dec         = 1'b0;
        start_drain     = 1'b0;
        ev              = EV_BUSY;
        eff_phase       = phase_reg;

        case (ctl_reg)
            ST_IN: begin
                if (s_valid && s_ready) begin
                    last_time_next = s_data.time_us;
                    if (gap_hit) begin
                        eff_phase = PH_ADDR;
                    end else if (phase_reg == PH_IDLE) begin
                        eff_phase = PH_SKIP;
                        err_inc   = 1'b1;
                    end
                    if (cut) begin
                        err_inc = 1'b1;
                    end

                    case (eff_phase)
                        PH_ADDR: begin
                            frame_addr_next = s_data.rx_byte;
                            crc_next        = crc_fed;
                            phase_next      = PH_LEN;
                        end
                        PH_LEN: begin
                            if (s_data.rx_byte > PMAX_B) begin
                                err_inc    = 1'b1;
                                phase_next = PH_SKIP;
                                ev         = EV_LEN_ERR;
                            end else begin
                                frame_len_next = s_data.rx_byte[6:0];
                                crc_next       = crc_fed;
                                position_next  = 7'd0;
                                phase_next     = (s_data.rx_byte == 8'd0) ? PH_CRCL : PH_DATA;
                            end
                        end
                        PH_DATA: begin
                            buf_wr_en     = position_reg < PMAX_L;
                            crc_next      = crc_fed;
                            position_next = pos_inc;
                            if (pos_inc >= frame_len_reg) begin
                                phase_next = PH_CRCL;
                            end
                        end
                        PH_CRCL: begin
                            crc_low_next = s_data.rx_byte;
                            phase_next   = PH_CRCH;
                        end
                        PH_CRCH: begin
                            phase_next = PH_IDLE;
                            if ({s_data.rx_byte, crc_low_reg} == crc_reg) begin
                                good_cnt_next = good_cnt_reg + 7'd1;
                                // every 128th good frame forgives one error
                                err_dec = (good_cnt_next == 7'd0) && (tally_reg != 16'd0);
                                if (frame_addr_reg == own_addr_reg) begin
                                    if (frame_len_reg == 7'd0) begin
                                        ev = EV_EMPTY;
                                    end else begin
                                        start_drain = 1'b1;
                                    end
                                end else begin
                                    ev = EV_OTHER;
                                end
                            end else begin
                                err_inc = 1'b1;
                                ev      = EV_CRC_ERR;
                            end
                        end
                        default: begin
                            phase_next = PH_SKIP;
                            ev         = EV_STRAY;
                        end
                    endcase

                    if (err_inc && (tally_reg != TALLY_MAX)) begin
                        tally_next = tally_reg + 16'd1;
                    end else if (err_dec) begin
                        tally_next = tally_reg - 16'd1;
                    end

                    if (cut) begin
                        out_load    = 1'b1;
                        m_data_next = '{EV_GAP_CUT, 8'd0, 6'd0, 1'b0, tally_next};
                        ctl_next    = ST_SECOND;
                    end else if (start_drain) begin
                        drain_idx_next = 7'd0;
                        ctl_next       = ST_DRAIN;
                    end else begin
                        out_load    = 1'b1;
                        m_data_next = '{ev, 8'd0, 6'd0, 1'b1, tally_next};
                    end
                end
            end
            ST_SECOND: begin
                // byte after a cut is the address of the new frame
                if (out_free) begin
                    out_load    = 1'b1;
                    m_data_next = '{EV_BUSY, 8'd0, 6'd0, 1'b1, tally_reg};
                    ctl_next    = ST_IN;
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    m_data_next    = '{EV_PAYLOAD, buf_rd_byte, drain_idx_reg[5:0],
                                       drain_last, tally_reg};
                    drain_idx_next = drain_idx_reg + 7'd1;
                    if (drain_last) begin
                        ctl_next = ST_IN;
                    end
                end
            end
            default: begin
                ctl_next = ST_IN;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Buffer writes happen only in the data phase; the read port is always enabled,
    // but its data are used only while draining, when no write can happen.
    gfbr_payload_buf #(
        .DEPTH (PAYLOAD_MAX),
        .AW    (AW)
    ) u_payload_buf (
        .aclk    (aclk),
        .wr_en   (buf_wr_en),
        .wr_addr (position_reg[AW-1:0]),
        .wr_byte (s_data.rx_byte),
        .rd_addr (drain_idx_next[AW-1:0]),
        .rd_byte (buf_rd_byte)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg        <= ST_IN;
            phase_reg      <= PH_IDLE;
            last_time_reg  <= 32'd0;
            frame_addr_reg <= 8'd0;
            frame_len_reg  <= 7'd0;
            position_reg   <= 7'd0;
            crc_low_reg    <= 8'd0;
            crc_reg        <= CRC_INIT;
            tally_reg      <= 16'd0;
            good_cnt_reg   <= 7'd0;
            drain_idx_reg  <= 7'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            ctl_reg        <= ctl_next;
            phase_reg      <= phase_next;
            last_time_reg  <= last_time_next;
            frame_addr_reg <= frame_addr_next;
            frame_len_reg  <= frame_len_next;
            position_reg   <= position_next;
            crc_low_reg    <= crc_low_next;
            crc_reg        <= crc_next;
            tally_reg      <= tally_next;
            good_cnt_reg   <= good_cnt_next;
            drain_idx_reg  <= drain_idx_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg  <= TIMEOUT_RESET;
            own_addr_reg <= 8'd0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_FRAME_TIMEOUT: timeout_reg  <= cfg_data[19:0];
                CFG_OWN_ADDRESS:   own_addr_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    `GFBR_ASSERT_SAME(a_drain_in_range, aclk, aresetn, ctl_reg == ST_DRAIN,
        drain_idx_reg < frame_len_reg, "drain index past frame length")
    `GFBR_ASSERT_SAME(a_data_pos, aclk, aresetn, phase_reg == PH_DATA,
        (frame_len_reg != 7'd0) && (position_reg < frame_len_reg) && (frame_len_reg <= PMAX_L),
        "data phase position out of range")
    `GFBR_ASSERT_NEXT(a_cut_follow, aclk, aresetn,
        m_valid && m_ready && (m_data.event_res == EV_GAP_CUT),
        m_valid && (m_data.event_res == EV_BUSY) && m_data.last,
        "gap cut not followed by address result")
    `GFBR_ASSERT_SAME(a_payload_idx, aclk, aresetn, m_valid && (m_data.event_res == EV_PAYLOAD),
        {1'b0, m_data.payload_index} < PMAX_L, "payload index beyond buffer")

endmodule
